FILE: hdl/vsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types for the base-128 varint stream decoder: decoder phase and
// result status codes.
// ----------------------------------------------------------------------------
package vsd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DISCARD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_BAD_LEAD  = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    localparam int unsigned OUT_DATA_BITS = 72;
    localparam int unsigned OUT_VALUE_BITS = 64;
    localparam int unsigned COUNT_BITS = 4;

endpackage
`default_nettype wire

FILE: hdl/varint_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// varint_stream_decoder
// Decodes big-endian base-128 integers from a byte stream, bit 7 of each
// byte flagging continuation; optional signed mode, length and lead checks.
// The result is registered and appears on m_axis the cycle after the final byte.
// Throughput: one byte per cycle; the byte is merged into the accumulator
// in a single registered step. While a result waits on m_axis the input
// stalls and takes the next byte in the cycle that result leaves.
// Reset (synchronous, active low) returns the decoder to idle, clears the
// output valid and clears signed_mode.
// ----------------------------------------------------------------------------
module varint_stream_decoder #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,   // end_of_buffer
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [vsd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,  // value[63:0], byte_count[67:64]
    output logic [1:0]       m_axis_tuser,   // status
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int MAX_BYTES = VALUE_BITS / 7 + 1;
    localparam int LEAD_N    = (VALUE_BITS + 6) / 7;
    localparam int CB        = vsd_pkg::COUNT_BITS;

    vsd_pkg::t_phase           r_phase, n_phase;
    logic [VALUE_BITS-1:0]     r_acc, n_acc;
    logic [VALUE_BITS-1:0]     r_fill, n_fill;
    logic [CB-1:0]             r_cnt, n_cnt;
    logic [6:0]                r_lead, n_lead;
    logic                      r_signed_mode;

    logic                      r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0]     r_value, n_value;
    vsd_pkg::t_status          r_status, n_status;
    logic [CB-1:0]             r_count, n_count;

    logic                      s_accept;
    logic                      first;
    logic                      neg;
    logic                      ok;
    logic                      emit;
    logic [2:0]                k;
    logic [6:0]                hi;

    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == 1'b0) ? {31'b0, r_signed_mode} : 32'b0;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_count, vsd_pkg::OUT_VALUE_BITS'(r_value)};
    assign m_axis_tuser  = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_signed_mode <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= vsd_pkg::PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
        r_acc    <= n_acc;
        r_fill   <= n_fill;
        r_cnt    <= n_cnt;
        r_lead   <= n_lead;
        r_value  <= n_value;
        r_status <= n_status;
        r_count  <= n_count;
    end

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_lead      = r_lead;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_value     = r_value;
        n_status    = r_status;
        n_count     = r_count;
        first       = (r_phase != vsd_pkg::PH_COLLECT);
        neg         = 1'b0;
        ok          = 1'b1;
        emit        = 1'b0;
        k           = 3'(VALUE_BITS - 7 * (int'(n_cnt) - 1));
        hi          = 7'h7f;

        if (s_accept) begin
            case (r_phase)
                vsd_pkg::PH_DISCARD: begin
                    if (s_axis_tlast) begin
                        n_phase = vsd_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_lead = first ? s_axis_tdata[6:0] : r_lead;
                    n_cnt  = (first ? CB'(0) : r_cnt) + CB'(1);
                    n_acc  = {(first ? {(VALUE_BITS-7){1'b0}} : r_acc[VALUE_BITS-8:0]),
                              s_axis_tdata[6:0]};
                    n_fill = {(first ? {(VALUE_BITS-7){1'b1}} : r_fill[VALUE_BITS-8:0]),
                              7'b0};
                    k      = 3'(VALUE_BITS - 7 * (int'(n_cnt) - 1));
                    hi     = 7'(7'h7f << k);
                    neg    = r_signed_mode && n_lead[6];
                    if (s_axis_tdata[7]) begin
                        if (n_cnt >= CB'(MAX_BYTES)) begin
                            emit     = 1'b1;
                            n_status = vsd_pkg::ST_TOO_LONG;
                            n_value  = '0;
                        end else if (s_axis_tlast) begin
                            emit     = 1'b1;
                            n_status = vsd_pkg::ST_TRUNCATED;
                            n_value  = '0;
                        end else begin
                            n_phase = vsd_pkg::PH_COLLECT;
                        end
                    end else begin
                        emit = 1'b1;
                        if (n_cnt < CB'(LEAD_N)) begin
                            n_status = vsd_pkg::ST_OK;
                            n_value  = n_acc | (neg ? n_fill : '0);
                        end else begin
                            ok = ((n_lead & hi) == (neg ? hi : 7'b0));
                            if (r_signed_mode && (n_acc[VALUE_BITS-1] != neg)) begin
                                ok = 1'b0;
                            end
                            n_status = ok ? vsd_pkg::ST_OK : vsd_pkg::ST_BAD_LEAD;
                            n_value  = ok ? n_acc : '0;
                        end
                    end
                    if (emit) begin
                        n_out_valid = 1'b1;
                        n_count     = n_cnt;
                        n_phase     = (n_status != vsd_pkg::ST_OK && !s_axis_tlast) ?
                                      vsd_pkg::PH_DISCARD : vsd_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_result_without_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && m_axis_tready && !s_accept) |=> !r_out_valid)
        else $error("result appeared without an accepted item");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_count != CB'(0) && r_count <= CB'(MAX_BYTES)))
        else $error("byte count out of range");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != vsd_pkg::ST_OK) |-> (r_value == '0))
        else $error("error result carries a nonzero value");

    a_discard_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_phase == vsd_pkg::PH_DISCARD) |=> !r_out_valid)
        else $error("result emitted while discarding");
`endif

endmodule
`default_nettype wire
